// ===== sv/servo_angle_ramp_pwm_defines.svh =====
// ----------------------------------------------------------------------------
// Servo angle ramp PWM: assertion macros
// Shared concurrent assertion wrappers on i_clk and i_rst_n.
// ----------------------------------------------------------------------------
`ifndef SERVO_ANGLE_RAMP_PWM_DEFINES_SVH
`define SERVO_ANGLE_RAMP_PWM_DEFINES_SVH

// Checked outside reset only.
`define SARP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define SARP_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== sv/sarp_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo angle ramp PWM: package
// Widths, constants, microcode word format and the control program.
// ----------------------------------------------------------------------------
package sarp_pkg;

    localparam int ANGLE_W   = 8;
    localparam int TIME_W    = 16;
    localparam int REG_W     = 12;
    localparam int CMP_W     = 13;
    localparam int STEP_W    = 12;
    localparam int DELTA_W   = 9;
    localparam int ACC_W     = DELTA_W + STEP_W + 1;
    localparam int DIV_W     = 21;   // dividend / quotient
    localparam int DEN_W     = 13;   // divisor, up to 2*4095
    localparam int REM_W     = DEN_W + 1;
    localparam int CNT_W     = $clog2(DIV_W + 1);
    localparam int CFG_IDX_W = 1;

    localparam int STEP_PERIOD_MS_DEF = 20;
    localparam int MAX_ANGLE          = 180;
    localparam int STEP_LIMIT         = 4095;
    localparam int OFFSET_RST         = 500;
    localparam int SPAN_RST           = 2000;

    // angle*span / 180 by reciprocal multiply, exact for any 20-bit product
    localparam int CMP_NUM_W   = ANGLE_W + REG_W;
    localparam int CMP_SH      = CMP_NUM_W + $clog2(MAX_ANGLE);
    localparam int CMP_RECIP_W = CMP_NUM_W + 2;
    localparam logic [CMP_RECIP_W-1:0] CMP_RECIP =
        CMP_RECIP_W'(((longint'(1) << CMP_SH) + longint'(MAX_ANGLE) - 1)
                     / longint'(MAX_ANGLE));

    localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN   = 1'd1;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_STEP_QUO,
        OP_DIV_STEP,
        OP_SET_RAMP,
        OP_TICK_ADV,
        OP_MUL_A,
        OP_MUL_B,
        OP_LD_ANGDIV,
        OP_SET_ANG,
        OP_SET_IMM,
        OP_LD_CMP,
        OP_CMP_QUO,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_TICK,
        C_IMMED,
        C_DIV_MORE,
        C_IDLE_TICK,
        C_OUT_FULL
    } t_cond;

    localparam int UPC_W = 5;
    typedef logic [UPC_W-1:0] t_upc;

    localparam t_upc L_IDLE     = 5'd0;
    localparam t_upc L_DISPATCH = 5'd1;
    localparam t_upc L_CMD      = 5'd2;
    localparam t_upc L_STEPDIV  = 5'd3;
    localparam t_upc L_SETRAMP  = 5'd4;
    localparam t_upc L_TICK     = 5'd5;
    localparam t_upc L_ADV      = 5'd6;
    localparam t_upc L_ANG      = 5'd7;
    localparam t_upc L_MULB     = 5'd8;
    localparam t_upc L_ANGDIV   = 5'd9;
    localparam t_upc L_ANGLOOP  = 5'd10;
    localparam t_upc L_SETANG   = 5'd11;
    localparam t_upc L_IMM      = 5'd12;
    localparam t_upc L_CMP      = 5'd13;
    localparam t_upc L_CMPDIV   = 5'd14;
    localparam t_upc L_EMIT     = 5'd15;
    localparam t_upc L_DONE     = 5'd16;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_upc  target;
    } t_uword;

    // Control store: jump to target when cond holds, else fall through.
    function automatic t_uword ucode(input t_upc addr);
        t_uword w;
        w = '{op: OP_NOP, cond: C_ALWAYS, target: L_IDLE};
        case (addr)
            L_IDLE:     w = '{op: OP_NOP,        cond: C_NO_INPUT,  target: L_IDLE};
            L_DISPATCH: w = '{op: OP_NOP,        cond: C_TICK,      target: L_TICK};
            L_CMD:      w = '{op: OP_NOP,        cond: C_IMMED,     target: L_IMM};
            L_STEPDIV:  w = '{op: OP_STEP_QUO,   cond: C_NEVER,     target: L_IDLE};
            L_SETRAMP:  w = '{op: OP_SET_RAMP,   cond: C_ALWAYS,    target: L_ANG};
            L_TICK:     w = '{op: OP_NOP,        cond: C_IDLE_TICK, target: L_CMP};
            L_ADV:      w = '{op: OP_TICK_ADV,   cond: C_NEVER,     target: L_IDLE};
            L_ANG:      w = '{op: OP_MUL_A,      cond: C_NEVER,     target: L_IDLE};
            L_MULB:     w = '{op: OP_MUL_B,      cond: C_NEVER,     target: L_IDLE};
            L_ANGDIV:   w = '{op: OP_LD_ANGDIV,  cond: C_NEVER,     target: L_IDLE};
            L_ANGLOOP:  w = '{op: OP_DIV_STEP,   cond: C_DIV_MORE,  target: L_ANGLOOP};
            L_SETANG:   w = '{op: OP_SET_ANG,    cond: C_ALWAYS,    target: L_CMP};
            L_IMM:      w = '{op: OP_SET_IMM,    cond: C_NEVER,     target: L_IDLE};
            L_CMP:      w = '{op: OP_LD_CMP,     cond: C_NEVER,     target: L_IDLE};
            L_CMPDIV:   w = '{op: OP_CMP_QUO,    cond: C_NEVER,     target: L_IDLE};
            L_EMIT:     w = '{op: OP_EMIT,       cond: C_OUT_FULL,  target: L_EMIT};
            L_DONE:     w = '{op: OP_NOP,        cond: C_ALWAYS,    target: L_IDLE};
            default:    w = '{op: OP_NOP,        cond: C_ALWAYS,    target: L_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== sv/sarp_ifs.sv =====
// ----------------------------------------------------------------------------
// Servo angle ramp PWM: channel interfaces
// Valid/ready channels for input items, result items and register writes.
// ----------------------------------------------------------------------------
interface sarp_in_if import sarp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [ANGLE_W-1:0] goal_angle;
    logic [TIME_W-1:0]  ramp_time_ms;

    modport source (output valid, mode, goal_angle, ramp_time_ms, input ready);
    modport sink   (input valid, mode, goal_angle, ramp_time_ms, output ready);
endinterface

interface sarp_out_if import sarp_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMP_W-1:0]   compare_value;
    logic [ANGLE_W-1:0] angle_now;
    logic               ramp_busy;

    modport source (output valid, compare_value, angle_now, ramp_busy, input ready);
    modport sink   (input valid, compare_value, angle_now, ramp_busy, output ready);
endinterface

interface sarp_cfg_if import sarp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [REG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/servo_angle_ramp_pwm.sv =====
// ----------------------------------------------------------------------------
// Servo angle ramp PWM
// Microcoded servo angle ramp generator with timer compare output.
// ----------------------------------------------------------------------------
// Each input item is a target command (mode 0) or a step tick (mode 1), and
// each gives exactly one result: the timer compare value, the angle it stands
// for and a busy flag while ramp steps remain. A command with zero ramp time,
// or one aiming at the current angle, sets the angle at once; otherwise it
// starts a linear ramp of ramp_time_ms / STEP_PERIOD_MS steps (1..4095) from
// the last angle given, and shows the first step right away. Ticks advance
// the ramp. Control runs from a 17-word microcode table that steers a small
// datapath: small multipliers for the ramp numerator and angle*span, a
// 21-bit restoring divider for the rounded ramp division (one quotient bit
// per cycle), and reciprocal multiplies for the divisions by constants
// (ramp time by the step period, angle*span by 180). Items are handled one
// at a time; the input is ready only while the sequencer sits at its idle
// word. The result register is loaded at the emit word, which holds while
// the output is stalled; the next item is accepted once the sequencer has
// gone on through the done word back to idle. The result register lets a
// new item start while the last result waits. Registers (0 = pulse_offset,
// 1 = pulse_span) are always ready and apply to the next result computed.
// ----------------------------------------------------------------------------
module servo_angle_ramp_pwm import sarp_pkg::*; #(
    parameter int STEP_PERIOD_MS = STEP_PERIOD_MS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sarp_in_if.sink   i_in,
    sarp_out_if.source o_out,
    sarp_cfg_if.sink  i_cfg
);

    // time / STEP_PERIOD_MS by reciprocal multiply, exact for 16-bit times
    localparam int STEP_SH      = TIME_W + $clog2(STEP_PERIOD_MS);
    localparam int STEP_RECIP_W = TIME_W + 2;
    localparam logic [STEP_RECIP_W-1:0] STEP_RECIP =
        STEP_RECIP_W'(((longint'(1) << STEP_SH) + longint'(STEP_PERIOD_MS) - 1)
                      / longint'(STEP_PERIOD_MS));

    // ---- sequencer ----
    t_upc   r_upc, n_upc;
    t_uword uw;
    logic   take;

    // ---- latched item ----
    logic               r_mode;
    logic [ANGLE_W-1:0] r_tgt;
    logic [TIME_W-1:0]  r_time;

    // ---- ramp state ----
    logic [ANGLE_W-1:0]        r_cur, n_cur;
    logic [ANGLE_W-1:0]        r_start, n_start;
    logic signed [DELTA_W-1:0] r_delta, n_delta;
    logic [STEP_W-1:0]         r_total, n_total;
    logic [STEP_W-1:0]         r_count, n_count;
    logic                      r_ramping, n_ramping;

    // ---- registers ----
    logic [REG_W-1:0] r_offset, r_span;

    // ---- datapath ----
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic [DIV_W-1:0]        r_qn, n_qn;      // dividend in, quotient out
    logic [REM_W-1:0]        r_rem, n_rem;
    logic [DEN_W-1:0]        r_den, n_den;
    logic [CNT_W-1:0]        r_bitcnt, n_bitcnt;

    // ---- result register ----
    logic               r_out_valid, n_out_valid;
    logic [CMP_W-1:0]   r_out_cmp, n_out_cmp;
    logic [ANGLE_W-1:0] r_out_angle, n_out_angle;
    logic               r_out_busy, n_out_busy;

    logic in_acc;
    logic out_full;

    logic [REM_W-1:0]               rem_sh;
    logic [REM_W-1:0]               rem_sub;
    logic                           div_ge;
    logic [ANGLE_W+STEP_W-1:0]      prod_a;
    logic signed [ACC_W-1:0]        prod_b;
    logic [ANGLE_W+REG_W-1:0]       prod_c;
    logic [TIME_W+STEP_RECIP_W-1:0] step_prod;
    logic [CMP_NUM_W+CMP_RECIP_W-1:0] cmp_prod;
    logic [STEP_W-1:0]              steps;
    logic [STEP_W:0]                cnt_inc;
    logic [STEP_W-1:0]              cnt_sat;
    logic [ACC_W-1:0]               num_pos;

    assign uw       = ucode(r_upc);
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_full = r_out_valid && !o_out.ready;

    assign i_in.ready          = (r_upc == L_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_out.valid         = r_out_valid;
    assign o_out.compare_value = r_out_cmp;
    assign o_out.angle_now     = r_out_angle;
    assign o_out.ramp_busy     = r_out_busy;

    // Restoring divider, one quotient bit per cycle.
    assign rem_sh  = {r_rem[REM_W-2:0], r_qn[DIV_W-1]};
    assign div_ge  = (rem_sh >= {1'b0, r_den});
    assign rem_sub = rem_sh - {1'b0, r_den};

    assign prod_a = r_start * r_total;
    assign prod_b = r_delta * $signed({1'b0, r_count});
    assign prod_c = r_cur * r_span;

    // Reciprocal products; the quotient sits above the shift point.
    assign step_prod = r_time * STEP_RECIP;
    assign cmp_prod  = r_qn[CMP_NUM_W-1:0] * CMP_RECIP;

    // Step count from the quotient: clamp to 1..4095.
    always_comb begin
        if (r_qn > DIV_W'(STEP_LIMIT)) begin
            steps = STEP_W'(STEP_LIMIT);
        end else if (r_qn == '0) begin
            steps = STEP_W'(1);
        end else begin
            steps = r_qn[STEP_W-1:0];
        end
    end

    assign cnt_inc = {1'b0, r_count} + (STEP_W+1)'(1);
    assign cnt_sat = (cnt_inc > {1'b0, r_total}) ? r_total : cnt_inc[STEP_W-1:0];
    assign num_pos = r_acc[ACC_W-1] ? '0 : r_acc;

    // Jump condition.
    always_comb begin
        case (uw.cond)
            C_NEVER:     take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_NO_INPUT:  take = !in_acc;
            C_TICK:      take = r_mode;
            C_IMMED:     take = (r_time == '0) || (r_tgt == r_cur);
            C_DIV_MORE:  take = (r_bitcnt != CNT_W'(1));
            C_IDLE_TICK: take = !r_ramping;
            C_OUT_FULL:  take = out_full;
            default:     take = 1'b0;
        endcase
        n_upc = take ? uw.target : r_upc + t_upc'(1);
    end

    // Datapath actions of the current control word.
    always_comb begin
        n_cur       = r_cur;
        n_start     = r_start;
        n_delta     = r_delta;
        n_total     = r_total;
        n_count     = r_count;
        n_ramping   = r_ramping;
        n_acc       = r_acc;
        n_qn        = r_qn;
        n_rem       = r_rem;
        n_den       = r_den;
        n_bitcnt    = r_bitcnt;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_cmp   = r_out_cmp;
        n_out_angle = r_out_angle;
        n_out_busy  = r_out_busy;

        case (uw.op)
            OP_NOP: begin
            end
            OP_STEP_QUO: begin
                n_qn = DIV_W'(step_prod >> STEP_SH);
            end
            OP_DIV_STEP: begin
                n_rem    = div_ge ? rem_sub : rem_sh;
                n_qn     = {r_qn[DIV_W-2:0], div_ge};
                n_bitcnt = r_bitcnt - CNT_W'(1);
            end
            OP_SET_RAMP: begin
                n_total   = steps;
                n_start   = r_cur;
                n_delta   = $signed({1'b0, r_tgt}) - $signed({1'b0, r_cur});
                n_count   = STEP_W'(1);
                n_ramping = (steps != STEP_W'(1));
            end
            OP_TICK_ADV: begin
                n_count   = cnt_sat;
                n_ramping = (cnt_sat < r_total);
            end
            OP_MUL_A: begin
                n_acc = $signed({{(ACC_W-ANGLE_W-STEP_W){1'b0}}, prod_a});
            end
            OP_MUL_B: begin
                n_acc = r_acc + prod_b;
            end
            OP_LD_ANGDIV: begin
                // (2*num + total) / (2*total) rounds half up
                n_qn     = DIV_W'({num_pos, 1'b0}) + DIV_W'(r_total);
                n_den    = {r_total, 1'b0};
                n_rem    = '0;
                n_bitcnt = CNT_W'(DIV_W);
            end
            OP_SET_ANG: begin
                n_cur = (r_qn > DIV_W'(MAX_ANGLE)) ? ANGLE_W'(MAX_ANGLE)
                                                   : r_qn[ANGLE_W-1:0];
            end
            OP_SET_IMM: begin
                n_cur     = r_tgt;
                n_ramping = 1'b0;
                n_count   = '0;
            end
            OP_LD_CMP: begin
                n_qn = DIV_W'(prod_c);
            end
            OP_CMP_QUO: begin
                n_qn = DIV_W'(cmp_prod >> CMP_SH);
            end
            OP_EMIT: begin
                if (!out_full) begin
                    n_out_valid = 1'b1;
                    n_out_cmp   = CMP_W'(r_offset) + r_qn[CMP_W-1:0];
                    n_out_angle = r_cur;
                    n_out_busy  = r_ramping;
                end
            end
            default: begin
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= L_IDLE;
            r_cur       <= '0;
            r_start     <= '0;
            r_delta     <= '0;
            r_total     <= '0;
            r_count     <= '0;
            r_ramping   <= 1'b0;
            r_out_valid <= 1'b0;
            r_offset    <= REG_W'(OFFSET_RST);
            r_span      <= REG_W'(SPAN_RST);
        end else begin
            r_upc       <= n_upc;
            r_cur       <= n_cur;
            r_start     <= n_start;
            r_delta     <= n_delta;
            r_total     <= n_total;
            r_count     <= n_count;
            r_ramping   <= n_ramping;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_OFFSET: r_offset <= i_cfg.data;
                    REG_SPAN:   r_span   <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode <= i_in.mode;
            r_tgt  <= (i_in.goal_angle > ANGLE_W'(MAX_ANGLE)) ? ANGLE_W'(MAX_ANGLE)
                                                             : i_in.goal_angle;
            r_time <= i_in.ramp_time_ms;
        end
        r_acc       <= n_acc;
        r_qn        <= n_qn;
        r_rem       <= n_rem;
        r_den       <= n_den;
        r_bitcnt    <= n_bitcnt;
        r_out_cmp   <= n_out_cmp;
        r_out_angle <= n_out_angle;
        r_out_busy  <= n_out_busy;
    end

    // ---- checks ----
`include "servo_angle_ramp_pwm_defines.svh"

    `SARP_ASSERT(a_ramp_count, r_ramping |-> (r_count < r_total), "ramp count past total")
    `SARP_ASSERT(a_emit_hold, (r_upc == L_EMIT) && out_full |=> (r_upc == L_EMIT), "emit skipped on stall")
    `SARP_ASSERT(a_accept_start, in_acc |=> (r_upc == L_DISPATCH), "accepted item not dispatched")
    `SARP_ASSERT_RST(a_reset_idle, !i_rst_n |=> (r_upc == L_IDLE) && !r_out_valid, "reset not idle")

endmodule
